/* hw/rtl/rwsd_pkg.sv */
package rwsd_pkg;

    // GPS parity masks over the 30-bit word, D1 at bit 29
    localparam logic [29:0] MASK_D25 = 30'h3b1f3480;
    localparam logic [29:0] MASK_D26 = 30'h1d8f9a40;
    localparam logic [29:0] MASK_D27 = 30'h2ec7cd00;
    localparam logic [29:0] MASK_D28 = 30'h1763e680;
    localparam logic [29:0] MASK_D29 = 30'h2bb1f340;
    localparam logic [29:0] MASK_D30 = 30'h0b7a89c0;

    localparam logic [7:0] PREAMBLE_RESET = 8'h66;
    localparam logic [2:0] BYTES_PER_WORD = 3'd5;
    localparam int NUM_ALIGN = 6;
    // oldest alignment ends at offset 5, its first bit at offset 34
    localparam int WIN_W = 35;

    typedef struct packed {
        logic        preamble_hit;
        logic        parity_ok;
        logic [23:0] data;
        logic        d29;
        logic        d30;
    } word_chk_t;

    typedef struct packed {
        logic [23:0] word_data;
        logic        parity_ok;
        logic [5:0]  word_index;
        logic        last_of_frame;
    } out_item_t;

    function automatic logic [5:0] gps_parity(
        input logic [23:0] data,
        input logic        d29,
        input logic        d30
    );
        logic [29:0] w;
        logic [5:0]  p;
        w    = {data, 6'd0};
        p[5] = ^(w & MASK_D25) ^ d29;
        p[4] = ^(w & MASK_D26) ^ d30;
        p[3] = ^(w & MASK_D27) ^ d29;
        p[2] = ^(w & MASK_D28) ^ d30;
        p[1] = ^(w & MASK_D29) ^ d30;
        p[0] = ^(w & MASK_D30) ^ d29;
        return p;
    endfunction

endpackage

/* hw/rtl/rtcm2_word_sync_deframer.sv */
// RTCM v2 word synchronizer and deframer.
//
// s_ channel: one received byte per transaction in s_tdata; bits 5..0 carry
// stream bits, bit 0 first in time. m_ channel: one word's 24 data bits per result,
// polarity corrected, with its parity flag and position in the frame; tlast
// marks the final word of a frame. Most bytes produce no result: while
// locked, a word comes out every fifth byte.
// cfg_wr_en/cfg_wr_data load the 8-bit preamble pattern (reset 0x66).
//
// A result appears on m_tvalid the cycle after the byte that
// completes it. Throughput: one byte per cycle while s_tready is high; the six
// alignment checks of a byte and the frame bookkeeping settle combinationally
// between the byte handshake and the single output register.
// Reset clears the bit window and returns to hunting with D29/D30 set.
// When the receiver stalls, the output register holds its transaction and
// s_tready drops only while a result is held and m_tready is low.
module rtcm2_word_sync_deframer import rwsd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [23:0] word_data, [24] parity_ok, [30:25] word_index
    output logic        m_tlast    // last_of_frame
);

    logic [WIN_W-1:0] window_reg, window_next;
    logic             locked_reg, locked_next;
    logic [2:0]       align_reg, align_next;
    logic [2:0]       byte_cnt_reg, byte_cnt_next;
    logic [5:0]       words_done_reg, words_done_next;
    logic [4:0]       frame_len_reg, frame_len_next;
    logic             d29_reg, d29_next;
    logic             d30_reg, d30_next;
    logic [7:0]       preamble_reg;

    logic             accept;
    logic             emit;
    out_item_t        item;
    logic [5:0]       shift_bits;
    word_chk_t        chk [NUM_ALIGN];
    word_chk_t        sel;
    logic             hit;
    logic [2:0]       hit_align;
    logic [4:0]       len_cur;
    logic             last;

    assign accept = s_tvalid && s_tready;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            shift_bits[5 - i] = s_tdata[i];
        end
    end

    assign window_next = accept ? {window_reg[WIN_W-7:0], shift_bits} : window_reg;

    genvar g;
    generate
        for (g = 0; g < NUM_ALIGN; g++) begin : g_align
            rwsd_word_check u_chk (
                .raw      (window_next[g +: 30]),
                .prev_d29 (d29_reg),
                .prev_d30 (d30_reg),
                .preamble (preamble_reg),
                .chk      (chk[g])
            );
        end
    endgenerate

    // oldest alignment wins: higher offsets overwrite
    always_comb begin
        hit       = 1'b0;
        hit_align = 3'd0;
        for (int k = 0; k < NUM_ALIGN; k++) begin
            if (chk[k].preamble_hit && chk[k].parity_ok) begin
                hit       = 1'b1;
                hit_align = 3'(k);
            end
        end
    end

    always_comb begin
        case (locked_reg ? align_reg : hit_align)
            3'd0:    sel = chk[0];
            3'd1:    sel = chk[1];
            3'd2:    sel = chk[2];
            3'd3:    sel = chk[3];
            3'd4:    sel = chk[4];
            3'd5:    sel = chk[5];
            default: sel = chk[0];
        endcase
    end

    assign len_cur = (words_done_reg == 6'd1) ? sel.data[7:3] : frame_len_reg;
    assign last    = (words_done_reg >= 6'd1) && (words_done_reg >= {1'b0, len_cur} + 6'd1);

    always_comb begin
        locked_next     = locked_reg;
        align_next      = align_reg;
        byte_cnt_next   = byte_cnt_reg;
        words_done_next = words_done_reg;
        frame_len_next  = frame_len_reg;
        d29_next        = d29_reg;
        d30_next        = d30_reg;
        emit            = 1'b0;
        item.word_data     = sel.data;
        item.parity_ok     = 1'b1;
        item.word_index    = 6'd0;
        item.last_of_frame = 1'b0;
        if (accept) begin
            if (!locked_reg) begin
                if (hit) begin
                    emit            = 1'b1;
                    locked_next     = 1'b1;
                    align_next      = hit_align;
                    byte_cnt_next   = 3'd0;
                    words_done_next = 6'd1;
                    frame_len_next  = 5'd0;
                    d29_next        = sel.d29;
                    d30_next        = sel.d30;
                end
            end else if (byte_cnt_reg + 3'd1 >= BYTES_PER_WORD) begin
                emit               = 1'b1;
                byte_cnt_next      = 3'd0;
                frame_len_next     = len_cur;
                d29_next           = sel.d29;
                d30_next           = sel.d30;
                item.parity_ok     = sel.parity_ok;
                item.word_index    = words_done_reg;
                item.last_of_frame = last;
                if (last) begin
                    locked_next     = 1'b0;
                    words_done_next = 6'd0;
                end else begin
                    words_done_next = words_done_reg + 6'd1;
                end
            end else begin
                byte_cnt_next = byte_cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg     <= '0;
            locked_reg     <= 1'b0;
            align_reg      <= 3'd0;
            byte_cnt_reg   <= 3'd0;
            words_done_reg <= 6'd0;
            frame_len_reg  <= 5'd0;
            d29_reg        <= 1'b1;
            d30_reg        <= 1'b1;
            preamble_reg   <= PREAMBLE_RESET;
        end else begin
            window_reg     <= window_next;
            locked_reg     <= locked_next;
            align_reg      <= align_next;
            byte_cnt_reg   <= byte_cnt_next;
            words_done_reg <= words_done_next;
            frame_len_reg  <= frame_len_next;
            d29_reg        <= d29_next;
            d30_reg        <= d30_next;
            if (cfg_wr_en) begin
                preamble_reg <= cfg_wr_data;
            end
        end
    end

    rwsd_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (emit),
        .item     (item),
        .ready    (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* hw/rtl/rwsd_word_check.sv */
module rwsd_word_check import rwsd_pkg::*; (
    input  logic [29:0] raw,
    input  logic        prev_d29,
    input  logic        prev_d30,
    input  logic [7:0]  preamble,
    output word_chk_t   chk
);

    logic [23:0] data;
    logic [7:0]  want;

    assign data = raw[29:6] ^ {24{prev_d30}};
    assign want = preamble ^ {8{prev_d30}};

    assign chk.preamble_hit = (raw[29:22] == want);
    assign chk.parity_ok    = (gps_parity(data, prev_d29, prev_d30) == raw[5:0]);
    assign chk.data         = data;
    assign chk.d29          = raw[1];
    assign chk.d30          = raw[0];

endmodule

/* hw/rtl/rwsd_out_reg.sv */
module rwsd_out_reg import rwsd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  out_item_t   item,
    output logic        ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic        m_tlast
);

    logic      valid_reg, valid_next;
    out_item_t item_reg;

    // free when empty or when the held transaction leaves this cycle
    assign ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, item_reg.word_index, item_reg.parity_ok, item_reg.word_data};
    assign m_tlast  = item_reg.last_of_frame;

endmodule

/* dv/rtcm2_word_sync_deframer_tb.sv */
`timescale 1ns / 1ps

module rtcm2_word_sync_deframer_tb;
    import rwsd_pkg::*;

    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_BYTES   = 125;
    localparam int NUM_PHASES    = 6;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       no_result;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [23:0] word_data, [24] parity_ok, [30:25] word_index
    logic        m_tlast;   // last_of_frame

    rtcm2_word_sync_deframer dut (
        .aclk,
        .aresetn,
        .cfg_wr_en,
        .cfg_wr_data,
        .s_tvalid,
        .s_tready,
        .s_tdata,
        .m_tvalid,
        .m_tready,
        .m_tdata,
        .m_tlast
    );

    // deframer prediction state
    logic [63:0] sync_win;
    logic        in_frame;
    logic [2:0]  word_off;
    logic [2:0]  byte_cnt;
    logic [5:0]  word_cnt;
    logic [4:0]  frame_len;
    logic        last_d29;
    logic        last_d30;
    logic [7:0]  preamble_reg;

    out_item_t words_due[$];
    stim_row_t byte_q[$];
    bit        tx_bits[$];
    stim_row_t cur;
    bit        in_flight;
    bit        calm;
    int        s_gap;
    int        m_gap;
    int        errors;
    int        bytes_queued;

    // with the reset preamble the window never holds the complemented pattern here
    stim_row_t opening_rows [0:5] = '{
        '{8'h00, 1'b1},
        '{8'hc0, 1'b1},
        '{8'h3f, 1'b1},
        '{8'hff, 1'b1},
        '{8'h00, 1'b1},
        '{8'h80, 1'b1}
    };

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [5:0] parity6(input logic [23:0] d, input logic d29,
                                           input logic d30);
        logic [29:0] w;
        w = {d, 6'd0};
        return {^(w & MASK_D25) ^ d29, ^(w & MASK_D26) ^ d30, ^(w & MASK_D27) ^ d29,
                ^(w & MASK_D28) ^ d30, ^(w & MASK_D29) ^ d30, ^(w & MASK_D30) ^ d29};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic deframe_byte(input logic [7:0] b, output bit hit, output out_item_t w);
        logic [5:0]  bits_in;
        logic [29:0] raw;
        logic [23:0] d;
        logic [7:0]  want;
        logic        is_last;
        hit = 1'b0;
        w   = '0;
        for (int i = 0; i < 6; i++) bits_in[5 - i] = b[i];
        sync_win = {sync_win[57:0], bits_in};
        if (!in_frame) begin
            want = preamble_reg ^ {8{last_d30}};
            // oldest alignment first
            for (int k = 5; k >= 0 && !hit; k--) begin
                raw = sync_win[k +: 30];
                d   = raw[29:6] ^ {24{last_d30}};
                if (raw[29:22] == want && parity6(d, last_d29, last_d30) == raw[5:0]) begin
                    hit         = 1'b1;
                    in_frame    = 1'b1;
                    word_off    = 3'(k);
                    byte_cnt    = '0;
                    word_cnt    = 6'd1;
                    frame_len   = '0;
                    last_d29    = raw[1];
                    last_d30    = raw[0];
                    w.word_data = d;
                    w.parity_ok = 1'b1;
                end
            end
        end else begin
            byte_cnt = byte_cnt + 3'd1;
            if (byte_cnt == BYTES_PER_WORD) begin
                byte_cnt = '0;
                raw = sync_win[word_off +: 30];
                d   = raw[29:6] ^ {24{last_d30}};
                if (word_cnt == 6'd1) frame_len = d[7:3];
                is_last = (word_cnt >= 6'd1) && ({1'b0, frame_len} + 6'd1 <= word_cnt);
                hit             = 1'b1;
                w.word_data     = d;
                w.parity_ok     = (parity6(d, last_d29, last_d30) == raw[5:0]);
                w.word_index    = word_cnt;
                w.last_of_frame = is_last;
                last_d29 = raw[1];
                last_d30 = raw[0];
                if (is_last) begin
                    in_frame = 1'b0;
                    word_cnt = '0;
                end else begin
                    word_cnt = word_cnt + 6'd1;
                end
            end
        end
    endtask

    task automatic tick();
        bit        hit;
        out_item_t w;
        out_item_t want;
        @(posedge aclk);
        if (m_tvalid && m_tready) begin
            if (words_due.size() == 0) begin
                $error("result transaction %h with no word expected", m_tdata);
                errors++;
            end else begin
                want = words_due.pop_front();
                if (m_tdata[23:0] !== want.word_data) begin
                    $error("word_data: expected %h, got %h", want.word_data, m_tdata[23:0]);
                    errors++;
                end
                if (m_tdata[24] !== want.parity_ok) begin
                    $error("parity_ok: expected %b, got %b", want.parity_ok, m_tdata[24]);
                    errors++;
                end
                if (m_tdata[30:25] !== want.word_index) begin
                    $error("word_index: expected %0d, got %0d", want.word_index,
                           m_tdata[30:25]);
                    errors++;
                end
                if (m_tlast !== want.last_of_frame) begin
                    $error("last_of_frame: expected %b, got %b", want.last_of_frame, m_tlast);
                    errors++;
                end
            end
        end
        if (s_tvalid && s_tready) begin
            deframe_byte(cur.rx_byte, hit, w);
            if (hit && !cur.no_result) words_due.push_back(w);
            in_flight = 1'b0;
        end
        // hold the byte until its transaction completes
        if (!in_flight) begin
            if (s_gap > 0) begin
                s_gap--;
                s_tvalid <= 1'b0;
            end else if (byte_q.size() != 0) begin
                cur = byte_q.pop_front();
                s_tdata   <= cur.rx_byte;
                s_tvalid  <= 1'b1;
                in_flight = 1'b1;
                s_gap     = pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        if (m_gap > 0) begin
            m_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            m_gap = pick_gap();
        end
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic no_result);
        stim_row_t row;
        row.rx_byte   = b;
        row.no_result = no_result;
        byte_q.push_back(row);
        bytes_queued++;
    endtask

    task automatic push_noise(input int nbits);
        repeat (nbits) tx_bits.push_back(1'($urandom_range(0, 1)));
    endtask

    // pack the bit stream into bytes, first bit in bit 0
    task automatic flush_bits();
        logic [7:0] b;
        while (tx_bits.size() % 6 != 0) tx_bits.push_back(1'($urandom_range(0, 1)));
        while (tx_bits.size() != 0) begin
            for (int i = 0; i < 6; i++) b[i] = tx_bits.pop_front();
            b[7:6] = 2'($urandom_range(0, 3));
            queue_byte(b, 1'b0);
        end
    endtask

    // encode a frame of 2 + n words; send only the first count, optionally flip one bit
    task automatic build_frame(input int n, input int count, input int flip_word,
                               input int flip_bit);
        logic [23:0] data;
        logic [29:0] raw;
        logic        d29;
        logic        d30;
        d29 = last_d29;
        d30 = last_d30;
        push_noise($urandom_range(0, 11));
        for (int i = 0; i < count; i++) begin
            data = 24'($urandom);
            if (i == 0) data[23:16] = preamble_reg;
            if (i == 1) data[7:3] = 5'(n);
            raw = {data ^ {24{d30}}, parity6(data, d29, d30)};
            if (i == flip_word) raw[flip_bit] = ~raw[flip_bit];
            d29 = raw[1];
            d30 = raw[0];
            for (int j = 29; j >= 0; j--) tx_bits.push_back(raw[j]);
        end
        flush_bits();
    endtask

    task automatic drain_input();
        while (byte_q.size() != 0 || in_flight) tick();
    endtask

    task automatic settle();
        drain_input();
        while (words_due.size() != 0) tick();
        repeat (SETTLE_CYCLES) tick();
    endtask

    task automatic load_preamble(input logic [7:0] v);
        cfg_wr_data <= v;
        cfg_wr_en   <= 1'b1;
        tick();
        cfg_wr_en   <= 1'b0;
        preamble_reg = v;
    endtask

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("rtcm2_word_sync_deframer test failed");
        $finish;
    end

    initial begin
        int r;
        int n;
        int start;
        bit c;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        m_tready    <= 1'b0;
        errors       = 0;
        bytes_queued = 0;
        in_flight    = 1'b0;
        calm         = 1'b0;
        s_gap        = 0;
        m_gap        = 0;
        sync_win     = '0;
        in_frame     = 1'b0;
        word_off     = '0;
        byte_cnt     = '0;
        word_cnt     = '0;
        frame_len    = '0;
        last_d29     = 1'b1;
        last_d30     = 1'b1;
        preamble_reg = PREAMBLE_RESET;
        repeat (RESET_CYCLES) tick();
        aresetn <= 1'b1;

        foreach (opening_rows[i]) queue_byte(opening_rows[i].rx_byte, opening_rows[i].no_result);
        drain_input();
        // header with a good preamble but bad parity: reject and keep hunting
        build_frame(0, 2, 0, $urandom_range(0, 5));
        drain_input();
        build_frame(0, 2, -1, 0);
        settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: load_preamble(8'h00);
                1: load_preamble(8'hff);
                3: load_preamble(PREAMBLE_RESET);
                default: load_preamble(8'($urandom_range(0, 255)));
            endcase
            start = bytes_queued;
            while (bytes_queued - start < PHASE_BYTES) begin
                drain_input();
                calm = ($urandom_range(0, 9) == 0);
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 31)
                                                      : $urandom_range(0, 4);
                    build_frame(n, n + 2, -1, 0);
                end else if (r < 72) begin
                    n = $urandom_range(0, 4);
                    build_frame(n, n + 2, $urandom_range(1, n + 1), $urandom_range(0, 29));
                end else if (r < 80) begin
                    n = $urandom_range(0, 4);
                    build_frame(n, n + 2, 0, $urandom_range(0, 5));
                end else if (r < 86) begin
                    n = $urandom_range(2, 6);
                    build_frame(n, $urandom_range(1, n + 1), -1, 0);
                end else if (r < 93) begin
                    push_noise(6 * $urandom_range(1, 15));
                    flush_bits();
                end else begin
                    // constant run: with a zero preamble several alignments can hit at once
                    c = (preamble_reg == 8'h00) ? last_d30 : 1'($urandom_range(0, 1));
                    repeat ($urandom_range(6, 12))
                        queue_byte({2'($urandom_range(0, 3)), {6{c}}}, 1'b0);
                end
            end
            calm = 1'b0;
            settle();
        end

        if (errors == 0 && words_due.size() == 0) begin
            $display("rtcm2_word_sync_deframer test passed");
        end else begin
            $display("rtcm2_word_sync_deframer test failed");
        end
        $finish;
    end

endmodule
